@@ src/swbp_pkg.sv @@
// Shared constants and helpers for the sliding window band power block.
// No dependencies.
`default_nettype none
package swbp_pkg;
    localparam int SAMPLE_W = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_BANDS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP0      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP1      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STEP2      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STEP3      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN       = 3'd6;

    localparam int STEP_REGS = 4;

    typedef logic signed [15:0] trig_t;

    function automatic logic [14:0] quarter_sine(input logic [6:0] k);
        logic [14:0] v;
        begin
            case (k)
                7'd0: v = 15'd0;      7'd1: v = 15'd804;    7'd2: v = 15'd1608;
                7'd3: v = 15'd2410;   7'd4: v = 15'd3212;   7'd5: v = 15'd4011;
                7'd6: v = 15'd4808;   7'd7: v = 15'd5602;   7'd8: v = 15'd6393;
                7'd9: v = 15'd7179;   7'd10: v = 15'd7962;  7'd11: v = 15'd8739;
                7'd12: v = 15'd9512;  7'd13: v = 15'd10278; 7'd14: v = 15'd11039;
                7'd15: v = 15'd11793; 7'd16: v = 15'd12539; 7'd17: v = 15'd13279;
                7'd18: v = 15'd14010; 7'd19: v = 15'd14732; 7'd20: v = 15'd15446;
                7'd21: v = 15'd16151; 7'd22: v = 15'd16846; 7'd23: v = 15'd17530;
                7'd24: v = 15'd18204; 7'd25: v = 15'd18868; 7'd26: v = 15'd19519;
                7'd27: v = 15'd20159; 7'd28: v = 15'd20787; 7'd29: v = 15'd21403;
                7'd30: v = 15'd22005; 7'd31: v = 15'd22594; 7'd32: v = 15'd23170;
                7'd33: v = 15'd23731; 7'd34: v = 15'd24279; 7'd35: v = 15'd24811;
                7'd36: v = 15'd25329; 7'd37: v = 15'd25832; 7'd38: v = 15'd26319;
                7'd39: v = 15'd26790; 7'd40: v = 15'd27245; 7'd41: v = 15'd27683;
                7'd42: v = 15'd28105; 7'd43: v = 15'd28510; 7'd44: v = 15'd28898;
                7'd45: v = 15'd29268; 7'd46: v = 15'd29621; 7'd47: v = 15'd29956;
                7'd48: v = 15'd30273; 7'd49: v = 15'd30571; 7'd50: v = 15'd30852;
                7'd51: v = 15'd31113; 7'd52: v = 15'd31356; 7'd53: v = 15'd31580;
                7'd54: v = 15'd31785; 7'd55: v = 15'd31971; 7'd56: v = 15'd32137;
                7'd57: v = 15'd32285; 7'd58: v = 15'd32412; 7'd59: v = 15'd32521;
                7'd60: v = 15'd32609; 7'd61: v = 15'd32678; 7'd62: v = 15'd32728;
                7'd63: v = 15'd32757; 7'd64: v = 15'd32767;
                default: v = 15'd0;
            endcase
            return v;
        end
    endfunction

    function automatic trig_t sine_at(input logic [7:0] idx);
        logic [6:0]  k;
        logic [14:0] m;
        begin
            k = {1'b0, idx[5:0]};
            m = idx[6] ? quarter_sine(7'd64 - k) : quarter_sine(k);
            return idx[7] ? -$signed({1'b0, m}) : $signed({1'b0, m});
        end
    endfunction
endpackage
`default_nettype wire

@@ src/swbp_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module swbp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ src/sliding_window_band_power_top.sv @@
// Sliding window band power: top level with sequencer and MAC datapath.
// Depends on swbp_pkg and swbp_ram.
//
//  channel | valid    | stall    | payload
//  in      | in_valid | in_stall | chan_index, sample_value, block_end
//  out     | out_valid| out_stall| out_channel, band_index, band_power, last_band
//  cfg     | cfg_we   | -        | cfg_index, cfg_data
//
// A plain sample holds in_stall high through ST_PTR (pointer read) and ST_WRITE
// (store write) after its beat, so the next sample waits for the return to ST_IDLE.
// A block end adds per band a setup state (ST_BAND), one sample read per window
// slot through the one memory read port, a drain state (ST_DRAIN), the scaling
// states ST_MAG, ST_MUL, ST_RND, ST_SQ and ST_SUM, and ST_OUT, held by out_stall.
// After reset a clearing pass writes zero to all MAX_CHANNELS*MAX_WINDOW slots,
// one per cycle, before the first sample is taken.
// out_stall holds the result.
`default_nettype none
module sliding_window_band_power_top #(
    parameter int MAX_CHANNELS = 16,
    parameter int MAX_WINDOW   = 256,
    parameter int MAX_BANDS    = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [3:0]  chan_index,
    input  wire logic signed [15:0] sample_value,
    input  wire logic        block_end,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [3:0]       out_channel,
    output logic [1:0]       band_index,
    output logic [31:0]      band_power,
    output logic             last_band,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int WIN_W  = $clog2(MAX_WINDOW);
    localparam int ADDR_W = CH_W + WIN_W;
    localparam int DEPTH  = MAX_CHANNELS * MAX_WINDOW;
    localparam int LEN_W  = WIN_W + 1;
    localparam int NB_MAX = (MAX_BANDS < swbp_pkg::STEP_REGS) ? MAX_BANDS
                                                                : swbp_pkg::STEP_REGS;

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_PTR   = 4'd2;
    localparam logic [3:0] ST_WRITE = 4'd3;
    localparam logic [3:0] ST_BAND  = 4'd4;
    localparam logic [3:0] ST_READ  = 4'd5;
    localparam logic [3:0] ST_DRAIN = 4'd6;
    localparam logic [3:0] ST_MAG   = 4'd7;
    localparam logic [3:0] ST_MUL   = 4'd8;
    localparam logic [3:0] ST_RND   = 4'd9;
    localparam logic [3:0] ST_SQ    = 4'd10;
    localparam logic [3:0] ST_SUM   = 4'd11;
    localparam logic [3:0] ST_OUT   = 4'd12;

    // configuration
    logic [8:0]  window_len_reg;
    logic [2:0]  num_bands_reg;
    logic [15:0] step_reg [swbp_pkg::STEP_REGS];
    logic [15:0] gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_len_reg <= 9'd64;
            num_bands_reg  <= 3'd3;
            for (int i = 0; i < swbp_pkg::STEP_REGS; i++)
            begin
                step_reg[i] <= 16'd0;
            end
            gain_reg <= 16'd512;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                swbp_pkg::REG_WINDOW_LEN: window_len_reg <= cfg_data[8:0];
                swbp_pkg::REG_NUM_BANDS:  num_bands_reg  <= cfg_data[2:0];
                swbp_pkg::REG_STEP0:      step_reg[0]    <= cfg_data;
                swbp_pkg::REG_STEP1:      step_reg[1]    <= cfg_data;
                swbp_pkg::REG_STEP2:      step_reg[2]    <= cfg_data;
                swbp_pkg::REG_STEP3:      step_reg[3]    <= cfg_data;
                swbp_pkg::REG_GAIN:       gain_reg       <= cfg_data;
                default: ;
            endcase
        end
    end

    // effective window length and band count
    logic [LEN_W-1:0] len_eff;
    logic [3:0]       nb_eff;
    always_comb
    begin
        if (window_len_reg == 9'd0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (32'(window_len_reg) > MAX_WINDOW)
        begin
            len_eff = LEN_W'(MAX_WINDOW);
        end
        else
        begin
            len_eff = LEN_W'(window_len_reg);
        end
        if (num_bands_reg == 3'd0)
        begin
            nb_eff = 4'd1;
        end
        else if (32'(num_bands_reg) > NB_MAX)
        begin
            nb_eff = 4'(NB_MAX);
        end
        else
        begin
            nb_eff = {1'b0, num_bands_reg};
        end
    end

    // memories
    logic              s_we;
    logic [ADDR_W-1:0] s_waddr, s_raddr;
    logic [15:0]       s_wdata, s_rdata;
    swbp_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_samples (
        .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(s_raddr), .rdata(s_rdata)
    );

    logic             p_we;
    logic [CH_W-1:0]  p_waddr, p_raddr;
    logic [WIN_W-1:0] p_wdata, p_rdata;
    swbp_ram #(.WIDTH(WIN_W), .DEPTH(MAX_CHANNELS)) u_ptrs (
        .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
        .raddr(p_raddr), .rdata(p_rdata)
    );

    // control state
    logic [3:0]        state_reg, state_next;
    logic [ADDR_W:0]   clr_reg, clr_next;
    logic [CH_W-1:0]   ch_reg, ch_next;
    logic [15:0]       smp_reg, smp_next;
    logic              end_reg, end_next;
    logic [WIN_W-1:0]  slot_reg, slot_next;
    logic [LEN_W-1:0]  cnt_reg, cnt_next;
    logic [1:0]        band_reg, band_next;
    logic [15:0]       phase_reg, phase_next;
    logic              rv_reg, rv_next;
    logic [7:0]        idx_reg, idx_next;
    logic signed [47:0] re_reg, re_next, im_reg, im_next;
    logic [47:0]       ma_reg, ma_next, mb_reg, mb_next;
    logic [63:0]       pa_reg, pa_next, pb_reg, pb_next;
    logic [31:0]       ra_reg, ra_next, rb_reg, rb_next;
    logic [63:0]       qa_reg, qa_next, qb_reg, qb_next;
    logic [31:0]       pw_reg, pw_next;
    logic              last_reg, last_next;

    logic in_ok;
    assign in_stall = (state_reg != ST_IDLE);
    assign in_ok    = in_valid && !in_stall;

    logic [15:0] step_cur;
    assign step_cur = step_reg[band_reg];

    logic signed [15:0] cos_v, sin_v;
    assign cos_v = swbp_pkg::sine_at(idx_reg + 8'd64);
    assign sin_v = swbp_pkg::sine_at(idx_reg);
    logic signed [31:0] prod_re, prod_im;
    assign prod_re = $signed(s_rdata) * cos_v;
    assign prod_im = $signed(s_rdata) * sin_v;

    localparam logic [47:0] LIM47 = 48'h8000_0000_0000;

    function automatic logic [47:0] mag47(input logic signed [47:0] a);
        logic [47:0] m;
        begin
            m = a[47] ? 48'(-a) : 48'(a);
            return m;
        end
    endfunction

    logic [63:0] sum65_lo;
    logic        sum65_c;

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        ch_next    = ch_reg;
        smp_next   = smp_reg;
        end_next   = end_reg;
        slot_next  = slot_reg;
        cnt_next   = cnt_reg;
        band_next  = band_reg;
        phase_next = phase_reg;
        rv_next    = 1'b0;
        idx_next   = idx_reg;
        re_next    = re_reg;
        im_next    = im_reg;
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        pa_next    = pa_reg;
        pb_next    = pb_reg;
        ra_next    = ra_reg;
        rb_next    = rb_reg;
        qa_next    = qa_reg;
        qb_next    = qb_reg;
        pw_next    = pw_reg;
        last_next  = last_reg;
        s_we    = 1'b0;
        s_waddr = {ch_reg, p_rdata};
        s_wdata = smp_reg;
        s_raddr = {ch_reg, slot_reg};
        p_we    = 1'b0;
        p_waddr = ch_reg;
        p_wdata = p_rdata + 1'b1;
        p_raddr = CH_W'(chan_index);
        {sum65_c, sum65_lo} = 65'(qa_reg) + 65'(qb_reg) + 65'(33'h8000);

        // accumulate the sample read last cycle
        if (rv_reg)
        begin
            re_next = re_reg + 48'(prod_re);
            im_next = im_reg + 48'(prod_im);
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                s_we    = 1'b1;
                s_waddr = clr_reg[ADDR_W-1:0];
                s_wdata = 16'd0;
                p_we    = (clr_reg < (ADDR_W+1)'(MAX_CHANNELS));
                p_waddr = clr_reg[CH_W-1:0];
                p_wdata = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (ADDR_W+1)'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_ok)
                begin
                    if (32'(chan_index) < MAX_CHANNELS)
                    begin
                        ch_next    = CH_W'(chan_index);
                        smp_next   = sample_value;
                        end_next   = block_end;
                        state_next = ST_PTR;
                    end
                end
            end
            ST_PTR:
            begin
                p_raddr = ch_reg;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                s_we = 1'b1;
                p_we = 1'b1;
                p_raddr = ch_reg;
                // start = p + 1 - len, modulo the ring
                slot_next = WIN_W'(p_rdata + 1'b1 - len_eff[WIN_W-1:0]);
                band_next = 2'd0;
                state_next = end_reg ? ST_BAND : ST_IDLE;
            end
            ST_BAND:
            begin
                re_next    = '0;
                im_next    = '0;
                phase_next = 16'd0;
                cnt_next   = len_eff;
                state_next = ST_READ;
                slot_next  = slot_reg;
                end_next   = 1'b0;
                ma_next    = {40'd0, slot_reg};
            end
            ST_READ:
            begin
                s_raddr    = {ch_reg, slot_reg};
                rv_next    = 1'b1;
                idx_next   = phase_reg[15:8];
                phase_next = phase_reg + step_cur;
                slot_next  = slot_reg + 1'b1;
                cnt_next   = cnt_reg - 1'b1;
                if (cnt_reg == LEN_W'(1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!rv_reg)
                begin
                    state_next = ST_MAG;
                    // restore start slot for the next band
                    slot_next = slot_reg - len_eff[WIN_W-1:0];
                end
            end
            ST_MAG:
            begin
                ma_next = (mag47(re_reg) > LIM47) ? LIM47 : mag47(re_reg);
                mb_next = (mag47(im_reg) > LIM47) ? LIM47 : mag47(im_reg);
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                pa_next = 64'(ma_reg) * 64'(gain_reg) + 64'h40_0000;
                pb_next = 64'(mb_reg) * 64'(gain_reg) + 64'h40_0000;
                state_next = ST_RND;
            end
            ST_RND:
            begin
                ra_next = (pa_reg[63:23] > 41'h8000_0000) ? 32'h8000_0000
                                                          : pa_reg[54:23];
                rb_next = (pb_reg[63:23] > 41'h8000_0000) ? 32'h8000_0000
                                                          : pb_reg[54:23];
                state_next = ST_SQ;
            end
            ST_SQ:
            begin
                qa_next = 64'(ra_reg) * 64'(ra_reg);
                qb_next = 64'(rb_reg) * 64'(rb_reg);
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                pw_next = (sum65_c || (sum65_lo[63:48] != 16'd0)) ? 32'hFFFF_FFFF
                                                                  : sum65_lo[47:16];
                last_next  = ({2'b00, band_reg} + 4'd1 == nb_eff);
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_stall)
                begin
                    if (last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        band_next  = band_reg + 1'b1;
                        state_next = ST_BAND;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            rv_reg    <= 1'b0;
            end_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            rv_reg    <= rv_next;
            end_reg   <= end_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg    <= ch_next;
        smp_reg   <= smp_next;
        slot_reg  <= slot_next;
        cnt_reg   <= cnt_next;
        band_reg  <= band_next;
        phase_reg <= phase_next;
        idx_reg   <= idx_next;
        re_reg    <= re_next;
        im_reg    <= im_next;
        ma_reg    <= ma_next;
        mb_reg    <= mb_next;
        pa_reg    <= pa_next;
        pb_reg    <= pb_next;
        ra_reg    <= ra_next;
        rb_reg    <= rb_next;
        qa_reg    <= qa_next;
        qb_reg    <= qb_next;
        pw_reg    <= pw_next;
        last_reg  <= last_next;
    end

    assign out_valid   = (state_reg == ST_OUT);
    assign out_channel = 4'(ch_reg);
    assign band_index  = band_reg;
    assign band_power  = pw_reg;
    assign last_band   = last_reg;
endmodule
`default_nettype wire

@@ src/swbp_checker.sv @@
// Port-level checks for the sliding window band power top level.
// Bound to sliding_window_band_power_top; no package use.
`default_nettype none
module swbp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [1:0]  band_index,
    input wire logic [31:0] band_power,
    input wire logic        last_band
);
    // a sample is never taken while a result waits
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(in_valid && !in_stall))
        else $error("input accepted during output");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(band_power))
        else $error("stalled beat changed");

    // after a non-last band beat the input stays stalled, as the run goes on
    a_band_next: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_band |=> in_stall)
        else $error("run ended early");

    // at most four bands, so band three always closes the run
    a_band3_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && band_index == 2'd3 |-> last_band)
        else $error("band three not marked last");

    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && last_band |=> !out_valid)
        else $error("beat right after the final band");
endmodule

bind sliding_window_band_power_top swbp_checker u_swbp_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .band_index(band_index),
    .band_power(band_power), .last_band(last_band)
);
`default_nettype wire

@@ test/swbp_checker.sv @@
// Checker for the sliding window band power block: mirrors the config port,
// predicts band powers per block end and compares every output beat.
// Depends on swbp_pkg.
`default_nettype none
module swbp_scoreboard (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic [3:0]  chan_index,
    input  wire logic [15:0] sample_value,
    input  wire logic        block_end,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [3:0]  out_channel,
    input  wire logic [1:0]  band_index,
    input  wire logic [31:0] band_power,
    input  wire logic        last_band,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    output int               fail_count,
    output int               pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCH = 16;
    localparam int NWIN = 256;

    typedef struct packed {
        logic [3:0]  chan;
        logic [1:0]  band;
        logic [31:0] power;
        logic        last;
    } band_result_t;

    logic signed [15:0] ring [NCH][NWIN];
    logic [7:0]  wr_slot [NCH];
    logic [8:0]  win_len;
    logic [2:0]  band_cnt;
    logic [15:0] step [4];
    logic [15:0] gain;
    band_result_t power_q[$];

    assign pending = power_q.size();

    function automatic logic signed [15:0] sin_tab(input logic [7:0] idx);
        int k;
        int v;
        k = int'(idx[5:0]);
        if (idx[6]) k = 64 - k;
        v = $rtoi($floor(32767.0 * $sin(k * 3.14159265358979 / 128.0) + 0.5));
        return 16'(idx[7] ? -v : v);
    endfunction

    function automatic longint unsigned scale_mag(input longint acc);
        longint unsigned m;
        m = acc < 0 ? -acc : acc;
        if (m > (64'd1 << 47)) m = 64'd1 << 47;
        m = (m * gain + (64'd1 << 22)) >> 23;
        if (m > (64'd1 << 31)) m = 64'd1 << 31;
        return m;
    endfunction

    task automatic predict_powers(input logic [3:0] ch);
        int len, nb, start, slot;
        longint re, im;
        logic [15:0] ph;
        logic [7:0] idx;
        longint unsigned a, c, pw;
        band_result_t r;
        len = win_len == 0 ? 1 : (win_len > NWIN ? NWIN : int'(win_len));
        nb = band_cnt == 0 ? 1 : (band_cnt > 4 ? 4 : int'(band_cnt));
        start = (int'(wr_slot[ch]) + NWIN - len) % NWIN;
        for (int b = 0; b < nb; b++)
        begin
            re = 0;
            im = 0;
            ph = 0;
            slot = start;
            for (int j = 0; j < len; j++)
            begin
                idx = ph[15:8];
                re += longint'(ring[ch][slot]) * sin_tab(idx + 8'd64);
                im += longint'(ring[ch][slot]) * sin_tab(idx);
                ph = ph + step[b];
                slot = (slot + 1) % NWIN;
            end
            a = scale_mag(re);
            c = scale_mag(im);
            pw = (a * a + c * c + (64'd1 << 15)) >> 16;
            if (pw > 64'hFFFF_FFFF) pw = 64'hFFFF_FFFF;
            r.chan = ch;
            r.band = b[1:0];
            r.power = pw[31:0];
            r.last = (b + 1 == nb);
            power_q = {power_q, r};
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        band_result_t e;
        if (!rst_n)
        begin
            foreach (ring[i, j]) ring[i][j] = '0;
            foreach (wr_slot[i]) wr_slot[i] = '0;
            win_len = 9'd64;
            band_cnt = 3'd3;
            foreach (step[i]) step[i] = '0;
            gain = 16'd512;
            fail_count = 0;
            power_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    swbp_pkg::REG_WINDOW_LEN: win_len = cfg_data[8:0];
                    swbp_pkg::REG_NUM_BANDS:  band_cnt = cfg_data[2:0];
                    swbp_pkg::REG_STEP0:      step[0] = cfg_data;
                    swbp_pkg::REG_STEP1:      step[1] = cfg_data;
                    swbp_pkg::REG_STEP2:      step[2] = cfg_data;
                    swbp_pkg::REG_STEP3:      step[3] = cfg_data;
                    swbp_pkg::REG_GAIN:       gain = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (power_q.size() == 0)
                begin
                    $error("unexpected output beat: channel %0d band %0d",
                           out_channel, band_index);
                    fail_count++;
                end
                else
                begin
                    e = power_q.pop_front();
                    if (out_channel !== e.chan)
                    begin
                        $error("out_channel: expected %0d, got %0d", e.chan, out_channel);
                        fail_count++;
                    end
                    if (band_index !== e.band)
                    begin
                        $error("band_index: expected %0d, got %0d", e.band, band_index);
                        fail_count++;
                    end
                    if (band_power !== e.power)
                    begin
                        $error("band_power: expected %0d, got %0d", e.power, band_power);
                        fail_count++;
                    end
                    if (last_band !== e.last)
                    begin
                        $error("last_band: expected %0d, got %0d", e.last, last_band);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                ring[chan_index][wr_slot[chan_index]] = sample_value;
                wr_slot[chan_index] = wr_slot[chan_index] + 8'd1;
                if (block_end) predict_powers(chan_index);
            end
        end
    end
endmodule
`default_nettype wire

@@ test/tb_sliding_window_band_power_top.sv @@
// Testbench top for the sliding window band power block: clock, reset,
// config phases, sample stimulus with random gaps and stalls, verdict.
// Depends on swbp_pkg, the block and swbp_scoreboard.
`default_nettype none
module tb_sliding_window_band_power_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 20000;
    localparam int LONG_HOLD  = 400;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [3:0]  chan_index = '0;
    logic [15:0] sample_value = '0;
    logic        block_end = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [3:0]  out_channel;
    logic [1:0]  band_index;
    logic [31:0] band_power;
    logic        last_band;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    int          fail_count;
    int          pending;
    int          idle_cycles = 0;
    bit          hold_req = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sliding_window_band_power_top u_dut (.*);
    swbp_scoreboard u_chk (.*);

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    always @(posedge clk)
    begin
        if (rst_n && idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_sliding_window_band_power_top: errors");
            $finish;
        end
    end

    // sink: random stall length per beat, one long hold when asked
    initial
    begin
        int gap;
        bit hold_done;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
            if (hold_req && !hold_done)
            begin
                gap = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (gap != 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!(out_valid && !out_stall)) @(posedge clk);
        end
    end

    // caller drops cfg_we after the last write
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    task automatic drain();
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_beat(input logic [3:0] ch, input logic [15:0] v,
                             input logic be, input bit gaps);
        int gap;
        gap = gaps ? ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 15)) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        chan_index <= ch;
        sample_value <= v;
        block_end <= be;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic set_config(input logic [8:0] wl, input logic [2:0] nb,
                              input logic [15:0] s0, input logic [15:0] s1,
                              input logic [15:0] s2, input logic [15:0] s3,
                              input logic [15:0] g);
        write_reg(swbp_pkg::REG_WINDOW_LEN, {7'd0, wl});
        write_reg(swbp_pkg::REG_NUM_BANDS, {13'd0, nb});
        write_reg(swbp_pkg::REG_STEP0, s0);
        write_reg(swbp_pkg::REG_STEP1, s1);
        write_reg(swbp_pkg::REG_STEP2, s2);
        write_reg(swbp_pkg::REG_STEP3, s3);
        write_reg(swbp_pkg::REG_GAIN, g);
        write_reg(3'd7, 16'hFFFF);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int phase;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, full scale, block ends on default config and on a window of one
        send_beat(4'd0, 16'h7FFF, 1'b0, 1'b0);
        send_beat(4'd0, 16'h8000, 1'b1, 1'b0);
        send_beat(4'd15, 16'h8000, 1'b1, 1'b0);
        in_valid <= 1'b0;
        drain();
        set_config(9'd1, 3'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd32768);
        send_beat(4'd3, 16'h8000, 1'b1, 1'b0);
        send_beat(4'd3, 16'h7FFF, 1'b1, 1'b1);
        in_valid <= 1'b0;
        drain();
        // window and band count out of range, wrapping steps, max gain, then full window with zero gain
        set_config(9'd0, 3'd0, 16'd32768, 16'hFFFF, 16'd1, 16'd16384, 16'hFFFF);
        send_beat(4'd5, 16'h8000, 1'b1, 1'b0);
        in_valid <= 1'b0;
        drain();
        set_config(9'd511, 3'd7, 16'd32768, 16'hFFFF, 16'd1, 16'd16384, 16'hFFFF);
        for (int i = 0; i < 8; i++)
            send_beat(4'd6, (i % 2) ? 16'h8000 : 16'h7FFF, i == 7, 1'b0);
        send_beat(4'd9, 16'h0000, 1'b1, 1'b0);
        in_valid <= 1'b0;
        drain();
        set_config(9'd256, 3'd4, 16'd0, 16'd8192, 16'd32768, 16'd1024, 16'd0);
        send_beat(4'd6, 16'h1234, 1'b1, 1'b0);
        in_valid <= 1'b0;
        drain();

        // random phases: several settings, mostly short windows
        for (phase = 0; phase < 8; phase++)
        begin
            set_config(phase == 7 ? 9'd256 : 9'($urandom_range(1, 24)),
                       3'($urandom_range(0, 7)), 16'($urandom()), 16'($urandom()),
                       16'($urandom_range(0, 32768)), 16'($urandom_range(0, 32768)),
                       16'($urandom()));
            if (phase == 3) hold_req = 1'b1;
            for (int i = 0; i < 48; i++)
            begin
                send_beat(4'($urandom()), 16'($urandom()),
                          $urandom_range(0, 4) == 0, 1'b1);
            end
            in_valid <= 1'b0;
            drain();
        end

        if (fail_count == 0)
            $display("tb_sliding_window_band_power_top: clean");
        else
            $display("tb_sliding_window_band_power_top: errors");
        $finish;
    end
endmodule
`default_nettype wire

@@ files.f @@
src/swbp_pkg.sv
src/swbp_ram.sv
src/sliding_window_band_power_top.sv
src/swbp_checker.sv
test/swbp_checker.sv
test/tb_sliding_window_band_power_top.sv
